// ----- hw/rtl/mtbp_pkg.sv -----
// Shared types and constants for the MCU threshold bitmap packer.
// Holds the item mode codes, register indexes and controller/datapath structs.
// No dependencies.
package mtbp_pkg;

    // Item modes
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W      = 3;
    localparam int         CFG_DATA_W     = 8;
    localparam logic [2:0] REG_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_IMG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_IMG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_MCU_WIDTH  = 3'd3;
    localparam logic [2:0] REG_MCU_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_THRESHOLD  = 8'd128;
    localparam logic [7:0] RST_IMG_WIDTH  = 8'd144;
    localparam logic [7:0] RST_IMG_HEIGHT = 8'd168;
    localparam logic [4:0] RST_MCU_SIZE   = 5'd8;

    // Controller to datapath commands
    typedef struct packed {
        logic in_load;   // latch the accepted item, step counters or clear them
        logic idx_calc;  // form the pixel/byte index
        logic mem_read;  // read the store byte
        logic finish;    // write back and load the output register
        logic clr_step;  // zero one store byte of the clearing sweep
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // sweep is at the last store byte
    } dp_stat_t;

endpackage

// ----- hw/rtl/mtbp_if.sv -----
// Valid/ready channel interfaces for the bitmap packer items and results.
// Depends on nothing; field widths follow the item and result formats.
interface mtbp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] sample;
    logic [7:0] read_row;
    logic [4:0] read_column;

    modport source (output valid, mode, sample, read_row, read_column, input ready);
    modport sink   (input valid, mode, sample, read_row, read_column, output ready);
endinterface

interface mtbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       frame_error;

    modport source (output valid, read_byte, frame_error, input ready);
    modport sink   (input valid, read_byte, frame_error, output ready);
endinterface

// ----- hw/rtl/mcu_threshold_bitmap_packer.sv -----
// Top level of the MCU threshold bitmap packer.
// Depends on mtbp_pkg, mtbp_if, mtbp_ctrl and mtbp_datapath.
//
// Usage:
//  req carries one transaction per item: mode (push sample, start frame, read
//  byte), the gray sample, and the row and byte column of a read. rsp returns
//  exactly one transaction per item: the bit-reversed store byte for a read
//  (0 otherwise) and the sticky frame error flag after that item.
//  cfg_we/cfg_index/cfg_data write threshold, image size and MCU size; write
//  them only while no item is in flight.
//  A push or read steps through accept, index multiply, store read, and
//  write-back with output load, as the single-port store read-modify-write
//  needs; the next item is accepted only after that last step.
//  A start frame zeroes the store one byte per cycle, (MAX_WIDTH*MAX_HEIGHT+7)/8
//  bytes (3024 by default), and returns its result after that sweep.
//  After reset the same sweep runs before req.ready rises; configuration
//  writes are taken during it.
//  The output register lets the next item be accepted while a result waits;
//  while rsp is stalled the following item waits at its final step.
module mcu_threshold_bitmap_packer
    import mtbp_pkg::*;
#(
    parameter int MAX_WIDTH  = 144,
    parameter int MAX_HEIGHT = 168
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mtbp_in_if.sink               req,
    mtbp_out_if.source            rsp
);

    ctrl_cmd_t ctl_cmd;
    dp_stat_t  dp_stat;

    // Controller
    mtbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (ctl_cmd)
    );

    // Datapath
    mtbp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_mode        (req.mode),
        .in_sample      (req.sample),
        .in_read_row    (req.read_row),
        .in_read_column (req.read_column),
        .cmd            (ctl_cmd),
        .stat           (dp_stat),
        .read_byte      (rsp.read_byte),
        .frame_error    (rsp.frame_error)
    );

    // No transaction is taken while the store is being cleared
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.clr_step |-> !req.ready)
        else $error("item accepted during store sweep");

    // Commands are mutually exclusive
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl_cmd.in_load, ctl_cmd.idx_calc, ctl_cmd.mem_read,
                  ctl_cmd.finish, ctl_cmd.clr_step}))
        else $error("overlapping datapath commands");

    // Finishing an item presents a result next cycle
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.finish |=> rsp.valid)
        else $error("finished item without result");

    // The store read always follows the index step
    a_idx_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.idx_calc |=> ctl_cmd.mem_read)
        else $error("index step not followed by store read");

endmodule

// ----- hw/rtl/mtbp_ctrl.sv -----
// Controller state machine of the bitmap packer: sequences each item and the
// store clearing sweep. Depends on mtbp_pkg.
module mtbp_ctrl
    import mtbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_mode,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_INIT = 3'd0;  // sweep after reset
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_IDX  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_WIPE = 3'd5;  // sweep for a start item

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Command decode
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.in_load  = in_ready && in_valid;
        cmd.idx_calc = (state_reg == ST_IDX);
        cmd.mem_read = (state_reg == ST_RD);
        cmd.finish   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        cmd.clr_step = (state_reg == ST_INIT) || (state_reg == ST_WIPE);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd.in_load)
                begin
                    unique case (in_mode)
                        MODE_PUSH, MODE_READ: state_next = ST_IDX;
                        MODE_START:           state_next = ST_WIPE;
                        default:              state_next = ST_DONE;
                    endcase
                end
            end
            ST_IDX:  state_next = ST_RD;
            ST_RD:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (cmd.finish)
                    state_next = ST_IDLE;
            end
            ST_WIPE:
            begin
                if (stat.clr_last)
                    state_next = ST_DONE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Output register valid
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/mtbp_datapath.sv -----
// Datapath of the bitmap packer: config registers, MCU scan counters, index
// arithmetic, the bitmap store and the output register. Depends on mtbp_pkg.
module mtbp_datapath
    import mtbp_pkg::*;
#(
    parameter int MAX_WIDTH  = 144,
    parameter int MAX_HEIGHT = 168
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            in_mode,
    input  logic [7:0]            in_sample,
    input  logic [7:0]            in_read_row,
    input  logic [4:0]            in_read_column,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat,
    output logic [7:0]            read_byte,
    output logic                  frame_error
);

    localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int IDX_W       = (ADDR_W + 3 > 18) ? ADDR_W + 3 : 18;
    localparam int BYTE_W      = IDX_W - 3;

    function automatic logic [7:0] bit_reverse(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[i] = v[7 - i];
        return r;
    endfunction

    // Configuration registers
    logic [7:0] thr_reg, width_reg, height_reg;
    logic [4:0] mcuw_reg, mcuh_reg;

    // Scan counters and sticky error
    logic [4:0] mcol_reg, mcol_next;
    logic [5:0] mrow_reg, mrow_next;
    logic       bcol_reg, bcol_next;
    logic       brow_reg, brow_next;
    logic [2:0] ix_reg, ix_next;
    logic [2:0] iy_reg, iy_next;
    logic       err_reg;

    // Clearing sweep
    logic [ADDR_W-1:0] clr_addr_reg;

    // Item payload registers
    logic [1:0]        mode_reg;
    logic [7:0]        rrow_reg;
    logic [4:0]        rcol_reg;
    logic [9:0]        row_reg;
    logic [8:0]        col_reg;
    logic              set_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        bit_reg;
    logic              hit_reg;
    logic [7:0]        rdata_reg;
    logic [7:0]        rbyte_out_reg;
    logic              ferr_out_reg;

    logic [7:0] store_mem [STORE_BYTES];

    // MCU geometry
    logic       wide_x, tall_y;
    logic [5:0] per_row, per_col;
    logic [8:0] w_pad, h_pad;

    always_comb
    begin
        wide_x  = mcuw_reg > 5'd8;
        tall_y  = mcuh_reg > 5'd8;
        w_pad   = {1'b0, width_reg} + (wide_x ? 9'd15 : 9'd7);
        h_pad   = {1'b0, height_reg} + (tall_y ? 9'd15 : 9'd7);
        per_row = wide_x ? 6'(w_pad >> 4) : 6'(w_pad >> 3);
        per_col = tall_y ? 6'(h_pad >> 4) : 6'(h_pad >> 3);
    end

    // Pixel position of the current sample
    logic [9:0] row_c;
    logic [8:0] col_c;
    logic       row_err, pix_on;

    always_comb
    begin
        row_c = (tall_y ? (10'(mrow_reg) << 4) : (10'(mrow_reg) << 3))
              + 10'({brow_reg, 3'b000}) + 10'(iy_reg);
        col_c = (wide_x ? (9'(mcol_reg) << 4) : (9'(mcol_reg) << 3))
              + 9'({bcol_reg, 3'b000}) + 9'(ix_reg);
        row_err = mrow_reg >= per_col;
        pix_on  = !row_err && (row_c < {2'b00, height_reg})
               && (col_c < {1'b0, width_reg}) && (in_sample > thr_reg);
    end

    // Counter advance, innermost first
    logic       c_ix, c_iy, c_bc, c_br, c_mc;
    logic [5:0] mcol_inc;

    always_comb
    begin
        mcol_inc  = 6'(mcol_reg) + 6'd1;
        c_ix      = (ix_reg == 3'd7);
        c_iy      = c_ix && (iy_reg == 3'd7);
        c_bc      = c_iy && (!wide_x || bcol_reg);
        c_br      = c_bc && (!tall_y || brow_reg);
        c_mc      = c_br && (mcol_inc >= per_row);
        ix_next   = ix_reg + 3'd1;
        iy_next   = c_ix ? iy_reg + 3'd1 : iy_reg;
        bcol_next = c_iy ? !c_bc : bcol_reg;
        brow_next = c_bc ? !c_br : brow_reg;
        mcol_next = c_br ? (c_mc ? 5'd0 : mcol_inc[4:0]) : mcol_reg;
        mrow_next = c_mc ? mrow_reg + 6'd1 : mrow_reg;
    end

    // Config, counters and sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= RST_THRESHOLD;
            width_reg    <= RST_IMG_WIDTH;
            height_reg   <= RST_IMG_HEIGHT;
            mcuw_reg     <= RST_MCU_SIZE;
            mcuh_reg     <= RST_MCU_SIZE;
            mcol_reg     <= '0;
            mrow_reg     <= '0;
            bcol_reg     <= 1'b0;
            brow_reg     <= 1'b0;
            ix_reg       <= '0;
            iy_reg       <= '0;
            err_reg      <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_THRESHOLD:  thr_reg    <= cfg_data;
                    REG_IMG_WIDTH:  width_reg  <= cfg_data;
                    REG_IMG_HEIGHT: height_reg <= cfg_data;
                    REG_MCU_WIDTH:  mcuw_reg   <= cfg_data[4:0];
                    REG_MCU_HEIGHT: mcuh_reg   <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.in_load && in_mode == MODE_START)
            begin
                mcol_reg <= '0;
                mrow_reg <= '0;
                bcol_reg <= 1'b0;
                brow_reg <= 1'b0;
                ix_reg   <= '0;
                iy_reg   <= '0;
                err_reg  <= 1'b0;
            end
            else if (cmd.in_load && in_mode == MODE_PUSH)
            begin
                if (row_err)
                    err_reg <= 1'b1;
                else
                begin
                    mcol_reg <= mcol_next;
                    mrow_reg <= mrow_next;
                    bcol_reg <= bcol_next;
                    brow_reg <= brow_next;
                    ix_reg   <= ix_next;
                    iy_reg   <= iy_next;
                end
            end
            // sweep wraps to zero after the last byte
            if (cmd.clr_step)
                clr_addr_reg <= stat.clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
        end
    end

    assign stat.clr_last = (clr_addr_reg == ADDR_W'(STORE_BYTES - 1));

    // Index arithmetic: pixel index for a push, byte index times 8 for a read
    logic             is_push;
    logic [9:0]       mul_a;
    logic [7:0]       mul_b;
    logic [8:0]       add_c;
    logic [17:0]      idx_sum;
    logic [IDX_W-1:0] idx_val;
    logic [BYTE_W-1:0] byte_idx;

    always_comb
    begin
        is_push  = (mode_reg == MODE_PUSH);
        mul_a    = is_push ? row_reg : 10'(rrow_reg);
        mul_b    = is_push ? width_reg : {3'b000, width_reg[7:3]};
        add_c    = is_push ? col_reg : 9'(rcol_reg);
        idx_sum  = 18'(mul_a * mul_b) + 18'(add_c);
        idx_val  = is_push ? IDX_W'(idx_sum) : (IDX_W'(idx_sum) << 3);
        byte_idx = idx_reg[IDX_W-1:3];
    end

    // Store write port: clearing sweep or read-modify-write of a push
    logic              wb_en, mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    always_comb
    begin
        wb_en     = cmd.finish && is_push && set_reg && hit_reg;
        mem_we    = cmd.clr_step || wb_en;
        mem_waddr = cmd.clr_step ? clr_addr_reg : addr_reg;
        mem_wdata = cmd.clr_step ? 8'h00 : (rdata_reg | (8'h80 >> bit_reg));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_read)
            rdata_reg <= store_mem[byte_idx[ADDR_W-1:0]];
    end

    // Item payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            mode_reg <= in_mode;
            rrow_reg <= in_read_row;
            rcol_reg <= in_read_column;
            row_reg  <= row_c;
            col_reg  <= col_c;
            set_reg  <= pix_on;
        end
        if (cmd.idx_calc)
            idx_reg <= idx_val;
        if (cmd.mem_read)
        begin
            addr_reg <= byte_idx[ADDR_W-1:0];
            bit_reg  <= idx_reg[2:0];
            hit_reg  <= byte_idx < BYTE_W'(STORE_BYTES);
        end
        if (cmd.finish)
        begin
            rbyte_out_reg <= (mode_reg == MODE_READ && hit_reg) ? bit_reverse(rdata_reg)
                                                                : 8'h00;
            ferr_out_reg  <= err_reg;
        end
    end

    assign read_byte   = rbyte_out_reg;
    assign frame_error = ferr_out_reg;

endmodule
